// File: design/dmg_pkg.sv
// dropout mask generator package: constants, codes and beat types
package dmg_pkg;

	localparam int BLOCK_LOG2  = 16;
	localparam int BLOCK_ELEMS = 1 << BLOCK_LOG2;
	localparam int ROOM_W      = BLOCK_LOG2 + 1;
	localparam int LANES       = 4;
	localparam int LANE_W      = 16;

	localparam logic [63:0] GOLDEN    = 64'h9E3779B97F4A7C15;
	localparam logic [63:0] MIX_A     = 64'hBF58476D1CE4E5B9;
	localparam logic [63:0] MIX_B     = 64'h94D049BB133111EB;
	localparam logic [63:0] BLOCK_MUL = 64'hD1B54A32D192ED03;

	localparam logic [63:0] SEED_RESET = GOLDEN;
	localparam logic [16:0] THRESH_RESET = 17'd0;
	localparam logic [31:0] KEEP_RESET = 32'h3F800000;

	typedef logic [1:0] action_t;
	localparam action_t ACT_NEXT     = 2'd0;
	localparam action_t ACT_EXPLICIT = 2'd1;
	localparam action_t ACT_AUTO     = 2'd2;
	localparam action_t ACT_RESERVE  = 2'd3;

	typedef logic [1:0] cfg_idx_t;
	localparam cfg_idx_t CFG_SEED   = 2'd0;
	localparam cfg_idx_t CFG_THRESH = 2'd1;
	localparam cfg_idx_t CFG_KEEP   = 2'd2;

	typedef logic [3:0] op_t;
	localparam op_t OP_NOP      = 4'd0;
	localparam op_t OP_DRAW     = 4'd1;
	localparam op_t OP_RESERVE  = 4'd2;
	localparam op_t OP_START    = 4'd3;
	localparam op_t OP_BLOCK    = 4'd4;
	localparam op_t OP_KEY_MIX  = 4'd5;
	localparam op_t OP_SM_MIX   = 4'd6;
	localparam op_t OP_MIX_B    = 4'd7;
	localparam op_t OP_KEY_SET  = 4'd8;
	localparam op_t OP_LOW_SET  = 4'd9;
	localparam op_t OP_HIGH_SET = 4'd10;

	typedef struct packed {
		action_t action;
		logic    need_reseed;
		logic    mul_done;
		logic    out_blocked;
	} status_t;

	typedef struct packed {
		logic [1:0]  action;
		logic [63:0] stream_number;
		logic [31:0] mask_length;
		logic [31:0] reserve_count;
	} in_t;

	typedef struct packed {
		logic [31:0] mask_lane0;
		logic [31:0] mask_lane1;
		logic [31:0] mask_lane2;
		logic [31:0] mask_lane3;
		logic [2:0]  lanes_valid;
		logic        last_group;
		logic [63:0] reserved_base;
	} out_t;

endpackage

// File: design/dropout_mask_generator_core.sv
// dropout mask generator top level: controller, datapath and config port
// a next-group or reserve beat is accepted each cycle while idle and the output is not blocked;
//   its result is registered for the next cycle. a start beat's result is returned likewise, then
//   the stream key takes three multiplies before the next beat is taken
// a group at a block boundary is reseeded by five multiplies before it is drawn and returned
// reset: seed 0x9E3779B97F4A7C15, threshold 0, keep 0x3F800000, all stream state zero
module dropout_mask_generator_core import dmg_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_stall,
	input  in_t         item,
	output logic        result_valid,
	input  logic        result_stall,
	output out_t        result,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  cfg_idx_t    cfg_index,
	input  logic [63:0] cfg_data
);

	op_t     op;
	status_t status;

	assign cfg_ready = 1'b1;

	dmg_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.status    (status),
		.op        (op)
	);

	dmg_dpath u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.op          (op),
		.item        (item),
		.status      (status),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result      (result),
		.cfg_valid   (cfg_valid && cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	a_last_has_lanes: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.last_group |-> result.lanes_valid != 3'd0)
		else $error("last group beat with no valid lanes");

	a_short_lane_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.lanes_valid != 3'd4 |-> result.mask_lane3 == 32'd0)
		else $error("invalid lane carries data");

	a_accept_op: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall |->
		op == OP_DRAW || op == OP_RESERVE || op == OP_START || op == OP_BLOCK)
		else $error("accepted beat without a matching command");

	a_reseed_busy: assert property (@(posedge clk) disable iff (!arst_n)
		op == OP_BLOCK |=> item_stall)
		else $error("beat taken during block reseed");

	a_start_result: assert property (@(posedge clk) disable iff (!arst_n)
		op == OP_START |=> result_valid)
		else $error("start beat produced no result");

endmodule

// File: design/dmg_mul.sv
// 64 by 64 low-half multiplier, one 32 by 32 partial product per cycle
module dmg_mul import dmg_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] a,
	input  logic [63:0] b,
	output logic        done,
	output logic [63:0] p
);

	localparam logic [1:0] STEP_LL = 2'd0;
	localparam logic [1:0] STEP_LH = 2'd1;
	localparam logic [1:0] STEP_HL = 2'd2;

	logic [63:0] a_q, b_q, acc_q;
	logic [1:0]  step_q;
	logic        busy_q, done_q;
	logic [31:0] ma, mb;
	logic [63:0] prod;

	assign ma   = (step_q == STEP_HL) ? a_q[63:32] : a_q[31:0];
	assign mb   = (step_q == STEP_LH) ? b_q[63:32] : b_q[31:0];
	assign prod = 64'(ma) * 64'(mb);
	assign done = done_q;
	assign p    = acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_LL;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= !start && busy_q && (step_q == STEP_HL);
			if (start) begin
				step_q <= STEP_LL;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				unique case (step_q)
					STEP_LL: step_q <= STEP_LH;
					STEP_LH: step_q <= STEP_HL;
					STEP_HL: busy_q <= 1'b0;
					default: busy_q <= 1'b0;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
			b_q <= b;
		end else if (busy_q) begin
			if (step_q == STEP_LL) begin
				acc_q <= prod;
			end else begin
				acc_q[63:32] <= acc_q[63:32] + prod[31:0];
			end
		end
	end

endmodule

// File: design/dmg_dpath.sv
// datapath: config registers, stream state, xorshift draw, splitmix operands, result register
module dmg_dpath import dmg_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  op_t         op,
	input  in_t         item,
	output status_t     status,
	output logic        result_valid,
	input  logic        result_stall,
	output out_t        result,
	input  logic        cfg_valid,
	input  cfg_idx_t    cfg_index,
	input  logic [63:0] cfg_data
);

	logic [63:0] seed_q, key_q, low_q, high_q, next_q, active_q, sm_q;
	logic [16:0] thr_q;
	logic [31:0] keep_q;
	logic [31:0] pos_q, len_q;
	logic        valid_q;
	out_t        out_q;

	logic                  mul_start, mul_done;
	logic [63:0]           mul_a, mul_b, mul_p;
	logic [63:0]           stream_sel, blk_idx, w_base, w, mix_out;
	logic [BLOCK_LOG2-1:0] offset;
	logic [ROOM_W-1:0]     room;
	logic                  len_nz;
	logic [63:0]           x, nh, r;
	logic [2:0]            cap_len, cap_room, n;
	logic [31:0]           lane_val [LANES];
	logic                  emit;
	out_t                  out_d;

	dmg_mul u_mul (
		.clk   (clk),
		.arst_n(arst_n),
		.start (mul_start),
		.a     (mul_a),
		.b     (mul_b),
		.done  (mul_done),
		.p     (mul_p)
	);

	assign offset     = pos_q[BLOCK_LOG2-1:0];
	assign len_nz     = (len_q != 32'd0);
	assign room       = ROOM_W'(BLOCK_ELEMS) - {1'b0, offset};
	assign blk_idx    = 64'(pos_q >> BLOCK_LOG2);
	assign stream_sel = (item.action == ACT_AUTO) ? next_q : item.stream_number;
	assign mix_out    = mul_p ^ (mul_p >> 31);

	assign status.action      = item.action;
	assign status.need_reseed = len_nz && (offset == '0);
	assign status.mul_done    = mul_done;
	assign status.out_blocked = valid_q && result_stall;

	// xorshift128+ step
	assign x  = low_q ^ (low_q << 23);
	assign nh = x ^ high_q ^ (x >> 17) ^ (high_q >> 26);
	assign r  = nh + high_q;

	assign cap_len  = (len_q < 32'(LANES)) ? len_q[2:0] : 3'(LANES);
	assign cap_room = (room < ROOM_W'(LANES)) ? room[2:0] : 3'(LANES);
	assign n        = (cap_room < cap_len) ? cap_room : cap_len;

	always_comb begin
		for (int k = 0; k < LANES; k++) begin
			if ((3'(k) < n) && ({1'b0, r[k*LANE_W +: LANE_W]} >= thr_q)) begin
				lane_val[k] = keep_q;
			end else begin
				lane_val[k] = 32'd0;
			end
		end
	end

	always_comb begin
		unique case (op)
			OP_KEY_MIX: w_base = seed_q ^ mul_p;
			OP_SM_MIX:  w_base = key_q ^ mul_p;
			default:    w_base = sm_q;
		endcase
		w = w_base + GOLDEN;
	end

	always_comb begin
		mul_start = 1'b1;
		mul_a     = w ^ (w >> 30);
		mul_b     = MIX_A;
		unique case (op)
			OP_START: begin
				mul_a = stream_sel;
				mul_b = GOLDEN;
			end
			OP_BLOCK: begin
				mul_a = blk_idx;
				mul_b = BLOCK_MUL;
			end
			OP_KEY_MIX, OP_SM_MIX, OP_LOW_SET: begin
				mul_b = MIX_A;
			end
			OP_MIX_B: begin
				mul_a = mul_p ^ (mul_p >> 27);
				mul_b = MIX_B;
			end
			default: mul_start = 1'b0;
		endcase
	end

	always_comb begin
		emit  = 1'b0;
		out_d = '0;
		unique case (op)
			OP_START: begin
				emit                = 1'b1;
				out_d.reserved_base = stream_sel;
			end
			OP_RESERVE: begin
				emit                = 1'b1;
				out_d.reserved_base = next_q;
			end
			OP_DRAW: begin
				emit                = 1'b1;
				out_d.mask_lane0    = lane_val[0];
				out_d.mask_lane1    = lane_val[1];
				out_d.mask_lane2    = lane_val[2];
				out_d.mask_lane3    = lane_val[3];
				out_d.lanes_valid   = n;
				out_d.last_group    = len_nz && ((len_q - 32'(n)) == 32'd0);
				out_d.reserved_base = active_q;
			end
			default: emit = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q   <= SEED_RESET;
			thr_q    <= THRESH_RESET;
			keep_q   <= KEEP_RESET;
			key_q    <= '0;
			low_q    <= '0;
			high_q   <= '0;
			pos_q    <= '0;
			len_q    <= '0;
			next_q   <= '0;
			active_q <= '0;
			valid_q  <= 1'b0;
		end else begin
			valid_q <= emit || (valid_q && result_stall);
			unique case (op)
				OP_START: begin
					active_q <= stream_sel;
					pos_q    <= '0;
					len_q    <= item.mask_length;
					low_q    <= '0;
					high_q   <= '0;
					if (item.action == ACT_AUTO) begin
						next_q <= next_q + 64'd1;
					end
				end
				OP_RESERVE: next_q <= next_q + 64'(item.reserve_count);
				OP_DRAW: begin
					if (len_nz) begin
						low_q  <= high_q;
						high_q <= nh;
						pos_q  <= pos_q + 32'(n);
						len_q  <= len_q - 32'(n);
					end
				end
				OP_KEY_SET: key_q <= mix_out;
				OP_LOW_SET: low_q <= mix_out;
				OP_HIGH_SET: begin
					// all-zero generator state is not allowed
					high_q <= ((low_q | mix_out) == 64'd0) ? 64'd1 : mix_out;
				end
				default: ;
			endcase
			if (cfg_valid) begin
				unique case (cfg_index)
					CFG_SEED: begin
						seed_q <= cfg_data;
						next_q <= '0;
					end
					CFG_THRESH: thr_q  <= cfg_data[16:0];
					CFG_KEEP:   keep_q <= cfg_data[31:0];
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_q <= out_d;
		end
		if ((op == OP_SM_MIX) || (op == OP_LOW_SET)) begin
			sm_q <= w;
		end
	end

	assign result_valid = valid_q;
	assign result       = out_q;

endmodule

// File: design/dmg_ctrl.sv
// controller: sequences mask starts, block reseeds, draws and reserves
module dmg_ctrl import dmg_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	output logic    item_stall,
	input  status_t status,
	output op_t     op
);

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_K0   = 4'd1;
	localparam logic [3:0] ST_K1   = 4'd2;
	localparam logic [3:0] ST_K2   = 4'd3;
	localparam logic [3:0] ST_B0   = 4'd4;
	localparam logic [3:0] ST_B1   = 4'd5;
	localparam logic [3:0] ST_B2   = 4'd6;
	localparam logic [3:0] ST_B3   = 4'd7;
	localparam logic [3:0] ST_B4   = 4'd8;
	localparam logic [3:0] ST_DRAW = 4'd9;

	logic [3:0] state_q, state_d;
	logic       ready;

	assign ready      = (state_q == ST_IDLE) && !status.out_blocked;
	assign item_stall = !ready;

	always_comb begin
		op      = OP_NOP;
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (item_valid && ready) begin
					unique case (status.action)
						ACT_NEXT: begin
							if (status.need_reseed) begin
								op      = OP_BLOCK;
								state_d = ST_B0;
							end else begin
								op = OP_DRAW;
							end
						end
						ACT_EXPLICIT, ACT_AUTO: begin
							op      = OP_START;
							state_d = ST_K0;
						end
						ACT_RESERVE: op = OP_RESERVE;
						default: op = OP_NOP;
					endcase
				end
			end
			ST_K0: begin
				if (status.mul_done) begin
					op      = OP_KEY_MIX;
					state_d = ST_K1;
				end
			end
			ST_K1: begin
				if (status.mul_done) begin
					op      = OP_MIX_B;
					state_d = ST_K2;
				end
			end
			ST_K2: begin
				if (status.mul_done) begin
					op      = OP_KEY_SET;
					state_d = ST_IDLE;
				end
			end
			ST_B0: begin
				if (status.mul_done) begin
					op      = OP_SM_MIX;
					state_d = ST_B1;
				end
			end
			ST_B1: begin
				if (status.mul_done) begin
					op      = OP_MIX_B;
					state_d = ST_B2;
				end
			end
			ST_B2: begin
				if (status.mul_done) begin
					op      = OP_LOW_SET;
					state_d = ST_B3;
				end
			end
			ST_B3: begin
				if (status.mul_done) begin
					op      = OP_MIX_B;
					state_d = ST_B4;
				end
			end
			ST_B4: begin
				if (status.mul_done) begin
					op      = OP_HIGH_SET;
					state_d = ST_DRAW;
				end
			end
			ST_DRAW: begin
				if (!status.out_blocked) begin
					op      = OP_DRAW;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// File: tb/dropout_mask_generator_core_tb.sv
`timescale 1ns / 100ps
// self-checking testbench for the dropout mask generator: directed rows and random traffic
module dropout_mask_generator_core_tb;
	import dmg_pkg::*;

	localparam int RUN_LIMIT     = 5_000_000;
	localparam int RANDOM_BEATS  = 1550;
	localparam int CALM_BEATS    = 200;
	localparam int HOLD_CYCLES   = 300;
	localparam int SETTLE_CYCLES = 32;
	localparam int TAIL_CYCLES   = 40;

	typedef struct {
		logic        is_cfg;
		cfg_idx_t    idx;
		logic [63:0] data;
		in_t         beat;
		logic        typed;
		out_t        want;
	} plan_row_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        item_valid;
	logic        item_stall;
	in_t         item;
	logic        result_valid;
	logic        result_stall;
	out_t        result;
	logic        cfg_valid;
	logic        cfg_ready;
	cfg_idx_t    cfg_index;
	logic [63:0] cfg_data;

	out_t      mask_due[$];
	plan_row_t plan[$];
	out_t      want_beat;
	int        mismatches = 0;
	int        beats_sent = 0;
	int        idle_odds = 0;
	int        cycles = 0;
	int        hold_count;
	logic      calm = 1'b0;
	logic      hold_long = 1'b0;

	// predictor state
	logic [63:0] seed_r;
	logic [16:0] thresh_r;
	logic [31:0] keep_r;
	logic [63:0] key_r;
	logic [63:0] lo_r;
	logic [63:0] hi_r;
	logic [63:0] next_id_r;
	logic [63:0] cur_id_r;
	logic [31:0] pos_r;
	logic [31:0] left_r;

	dropout_mask_generator_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #5 clk = ~clk;

	function automatic logic [63:0] mix64(input logic [63:0] x);
		logic [63:0] z;
		z = x + GOLDEN;
		z = (z ^ (z >> 30)) * MIX_A;
		z = (z ^ (z >> 27)) * MIX_B;
		return z ^ (z >> 31);
	endfunction

	function automatic void open_stream(input logic [63:0] id, input logic [31:0] len);
		key_r = mix64(seed_r ^ (id * GOLDEN));
		cur_id_r = id;
		pos_r = '0;
		left_r = len;
		lo_r = '0;
		hi_r = '0;
	endfunction

	function automatic out_t predict_mask(input in_t b);
		out_t        o;
		logic [63:0] x;
		logic [63:0] y;
		logic [63:0] r;
		logic [63:0] sm;
		logic [63:0] blk;
		logic [31:0] n;
		logic [31:0] room;
		logic [31:0] lane [LANES];
		int          k;
		o = '0;
		for (k = 0; k < LANES; k++)
			lane[k] = '0;
		o.reserved_base = cur_id_r;
		case (b.action)
			ACT_EXPLICIT: begin
				open_stream(b.stream_number, b.mask_length);
				o.reserved_base = cur_id_r;
			end
			ACT_AUTO: begin
				o.reserved_base = next_id_r;
				open_stream(next_id_r, b.mask_length);
				next_id_r = next_id_r + 64'd1;
			end
			ACT_RESERVE: begin
				o.reserved_base = next_id_r;
				next_id_r = next_id_r + {32'd0, b.reserve_count};
			end
			ACT_NEXT: begin
				if (left_r != 0) begin
					room = BLOCK_ELEMS - (pos_r % BLOCK_ELEMS);
					// block boundary: reseed from the stream key
					if (room == BLOCK_ELEMS) begin
						blk = {32'd0, pos_r} / BLOCK_ELEMS;
						sm = key_r ^ (blk * BLOCK_MUL);
						lo_r = mix64(sm);
						hi_r = mix64(sm + GOLDEN);
						if ((lo_r | hi_r) == 64'd0)
							hi_r = 64'd1;
					end
					x = lo_r;
					y = hi_r;
					lo_r = y;
					x = x ^ (x << 23);
					hi_r = x ^ y ^ (x >> 17) ^ (y >> 26);
					r = hi_r + y;
					n = LANES;
					if (left_r < n)
						n = left_r;
					if (room < n)
						n = room;
					for (k = 0; k < LANES; k++)
						if (k < n)
							lane[k] = ({1'b0, r[16*k +: 16]} < thresh_r) ? 32'd0 : keep_r;
					pos_r = pos_r + n;
					left_r = left_r - n;
					o.lanes_valid = n[2:0];
					o.last_group = (left_r == 0);
				end
			end
		endcase
		o.mask_lane0 = lane[0];
		o.mask_lane1 = lane[1];
		o.mask_lane2 = lane[2];
		o.mask_lane3 = lane[3];
		return o;
	endfunction

	function automatic in_t rand_beat();
		in_t b;
		b.action = action_t'($urandom_range(0, 3));
		b.stream_number = {$urandom, $urandom};
		b.mask_length = $urandom;
		b.reserve_count = $urandom;
		return b;
	endfunction

	function automatic plan_row_t reg_row(input cfg_idx_t idx, input logic [63:0] d);
		plan_row_t p;
		p.is_cfg = 1'b1;
		p.idx = idx;
		p.data = d;
		p.beat = '0;
		p.typed = 1'b0;
		p.want = '0;
		return p;
	endfunction

	function automatic plan_row_t beat_row(input action_t a, input logic [63:0] s,
			input logic [31:0] len, input logic [31:0] cnt);
		plan_row_t p;
		p.is_cfg = 1'b0;
		p.idx = CFG_SEED;
		p.data = '0;
		p.beat.action = a;
		p.beat.stream_number = s;
		p.beat.mask_length = len;
		p.beat.reserve_count = cnt;
		p.typed = 1'b0;
		p.want = '0;
		return p;
	endfunction

	function automatic plan_row_t known_row(input action_t a, input logic [63:0] s,
			input logic [31:0] len, input logic [31:0] cnt, input logic [2:0] nv,
			input logic lst, input logic [31:0] val, input logic [63:0] base);
		plan_row_t p;
		p = beat_row(a, s, len, cnt);
		p.typed = 1'b1;
		p.want.mask_lane0 = (nv > 0) ? val : 32'd0;
		p.want.mask_lane1 = (nv > 1) ? val : 32'd0;
		p.want.mask_lane2 = (nv > 2) ? val : 32'd0;
		p.want.mask_lane3 = (nv > 3) ? val : 32'd0;
		p.want.lanes_valid = nv;
		p.want.last_group = lst;
		p.want.reserved_base = base;
		return p;
	endfunction

	task automatic flag_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		mismatches++;
		$display("mismatch at cycle %0d on %s: got %h, expected %h",
			cycles, what, got, want);
	endtask

	task automatic offer_beat(input in_t b, input logic typed, input out_t want);
		out_t guess;
		if (!calm && $urandom_range(0, 15) < idle_odds) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		item_valid <= 1'b1;
		item <= b;
		do @(posedge clk); while (item_stall);
		guess = predict_mask(b);
		mask_due.push_back(typed ? want : guess);
		beats_sent++;
	endtask

	task automatic settle();
		item_valid <= 1'b0;
		while (mask_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [63:0] d);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_SEED: begin
				seed_r = d;
				next_id_r = '0;
			end
			CFG_THRESH: thresh_r = d[16:0];
			CFG_KEEP: keep_r = d[31:0];
			default: ;
		endcase
	endtask

	task automatic random_regs();
		logic wrote;
		settle();
		wrote = 1'b0;
		while (!wrote) begin
			if ($urandom_range(0, 1)) begin
				case ($urandom_range(0, 3))
					0: write_reg(CFG_SEED, 64'd0);
					1: write_reg(CFG_SEED, '1);
					default: write_reg(CFG_SEED, {$urandom, $urandom});
				endcase
				wrote = 1'b1;
			end
			if ($urandom_range(0, 1)) begin
				case ($urandom_range(0, 7))
					0: write_reg(CFG_THRESH, 64'd0);
					1: write_reg(CFG_THRESH, 64'd1);
					2: write_reg(CFG_THRESH, 64'd65535);
					3: write_reg(CFG_THRESH, 64'd65536);
					default: write_reg(CFG_THRESH, 64'($urandom_range(0, 65536)));
				endcase
				wrote = 1'b1;
			end
			if ($urandom_range(0, 1)) begin
				case ($urandom_range(0, 3))
					0: write_reg(CFG_KEEP, 64'd0);
					1: write_reg(CFG_KEEP, 64'hFFFF_FFFF);
					default: write_reg(CFG_KEEP, {32'd0, $urandom});
				endcase
				wrote = 1'b1;
			end
		end
		cfg_valid <= 1'b0;
		idle_odds = $urandom_range(0, 4);
	endtask

	// result side: random stall bursts and one long hold-off
	initial begin
		result_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_long) begin
				hold_long = 1'b0;
				result_stall <= 1'b1;
				hold_count = 0;
				while (hold_count < HOLD_CYCLES) begin
					@(posedge clk);
					hold_count++;
				end
				result_stall <= 1'b0;
			end else if (!calm && $urandom_range(0, 15) < idle_odds) begin
				result_stall <= 1'b1;
				repeat ($urandom_range(1, 16)) @(posedge clk);
				result_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			if (mask_due.size() == 0) begin
				flag_mismatch("beat with nothing pending", result.reserved_base, 64'd0);
			end else begin
				want_beat = mask_due.pop_front();
				if (result.mask_lane0 !== want_beat.mask_lane0)
					flag_mismatch("mask_lane0", result.mask_lane0, want_beat.mask_lane0);
				if (result.mask_lane1 !== want_beat.mask_lane1)
					flag_mismatch("mask_lane1", result.mask_lane1, want_beat.mask_lane1);
				if (result.mask_lane2 !== want_beat.mask_lane2)
					flag_mismatch("mask_lane2", result.mask_lane2, want_beat.mask_lane2);
				if (result.mask_lane3 !== want_beat.mask_lane3)
					flag_mismatch("mask_lane3", result.mask_lane3, want_beat.mask_lane3);
				if (result.lanes_valid !== want_beat.lanes_valid)
					flag_mismatch("lanes_valid", result.lanes_valid, want_beat.lanes_valid);
				if (result.last_group !== want_beat.last_group)
					flag_mismatch("last_group", result.last_group, want_beat.last_group);
				if (result.reserved_base !== want_beat.reserved_base)
					flag_mismatch("reserved_base", result.reserved_base,
						want_beat.reserved_base);
			end
		end
	end

	initial begin
		while (cycles < RUN_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		in_t         b;
		logic        cfg_open;
		logic [31:0] len;
		int          groups;
		int          first;
		int          len_pick;

		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		cfg_valid = 1'b0;
		cfg_index = CFG_SEED;
		cfg_data = '0;
		seed_r = SEED_RESET;
		thresh_r = THRESH_RESET;
		keep_r = KEEP_RESET;
		key_r = '0;
		lo_r = '0;
		hi_r = '0;
		next_id_r = '0;
		cur_id_r = '0;
		pos_r = '0;
		left_r = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed rows, reset config: threshold 0 keeps every valid lane
		plan.push_back(known_row(ACT_NEXT, '1, '1, '1, 3'd0, 1'b0, 32'd0, 64'd0));
		plan.push_back(known_row(ACT_RESERVE, 64'd0, 32'd0, 32'd0, 3'd0, 1'b0, 32'd0, 64'd0));
		plan.push_back(known_row(ACT_RESERVE, '1, '1, 32'hFFFF_FFFF, 3'd0, 1'b0, 32'd0,
			64'd0));
		plan.push_back(known_row(ACT_AUTO, '1, 32'd6, '1, 3'd0, 1'b0, 32'd0,
			64'hFFFF_FFFF));
		plan.push_back(known_row(ACT_NEXT, 64'd0, 32'd0, 32'd0, 3'd4, 1'b0, KEEP_RESET,
			64'hFFFF_FFFF));
		plan.push_back(known_row(ACT_NEXT, 64'd0, 32'd0, 32'd0, 3'd2, 1'b1, KEEP_RESET,
			64'hFFFF_FFFF));
		plan.push_back(known_row(ACT_NEXT, 64'd0, 32'd0, 32'd0, 3'd0, 1'b0, 32'd0,
			64'hFFFF_FFFF));
		plan.push_back(known_row(ACT_RESERVE, 64'd0, 32'd0, 32'd3, 3'd0, 1'b0, 32'd0,
			64'h1_0000_0000));
		plan.push_back(known_row(ACT_EXPLICIT, '1, 32'd0, 32'd0, 3'd0, 1'b0, 32'd0, '1));
		plan.push_back(known_row(ACT_NEXT, 64'd0, 32'd0, 32'd0, 3'd0, 1'b0, 32'd0, '1));
		plan.push_back(known_row(ACT_EXPLICIT, 64'd0, 32'd1, 32'd0, 3'd0, 1'b0, 32'd0,
			64'd0));
		plan.push_back(known_row(ACT_NEXT, 64'd0, 32'd0, 32'd0, 3'd1, 1'b1, KEEP_RESET,
			64'd0));
		plan.push_back(known_row(ACT_EXPLICIT, {16{4'h5}}, 32'd3, 32'd0, 3'd0, 1'b0, 32'd0,
			{16{4'h5}}));
		plan.push_back(known_row(ACT_NEXT, 64'd0, 32'd0, 32'd0, 3'd3, 1'b1, KEEP_RESET,
			{16{4'h5}}));
		plan.push_back(known_row(ACT_EXPLICIT, {16{4'hA}}, 32'hFFFF_FFFF, 32'd0, 3'd0, 1'b0,
			32'd0, {16{4'hA}}));
		plan.push_back(known_row(ACT_NEXT, 64'd0, 32'd0, 32'd0, 3'd4, 1'b0, KEEP_RESET,
			{16{4'hA}}));
		plan.push_back(known_row(ACT_AUTO, 64'd0, 32'd4, 32'd0, 3'd0, 1'b0, 32'd0,
			64'h1_0000_0003));
		plan.push_back(known_row(ACT_NEXT, 64'd0, 32'd0, 32'd0, 3'd4, 1'b1, KEEP_RESET,
			64'h1_0000_0003));
		// full threshold drops every lane
		plan.push_back(reg_row(CFG_THRESH, 64'd65536));
		plan.push_back(known_row(ACT_EXPLICIT, 64'd7, 32'd5, 32'd0, 3'd0, 1'b0, 32'd0, 64'd7));
		plan.push_back(known_row(ACT_NEXT, 64'd0, 32'd0, 32'd0, 3'd4, 1'b0, 32'd0, 64'd7));
		plan.push_back(reg_row(CFG_KEEP, 64'd0));
		plan.push_back(reg_row(CFG_THRESH, 64'd0));
		plan.push_back(known_row(ACT_NEXT, 64'd0, 32'd0, 32'd0, 3'd1, 1'b1, 32'd0, 64'd7));
		// seed write clears the auto stream counter
		plan.push_back(reg_row(CFG_SEED, 64'd0));
		plan.push_back(reg_row(CFG_KEEP, 64'hFFFF_FFFF));
		plan.push_back(known_row(ACT_AUTO, 64'd0, 32'd12, 32'd0, 3'd0, 1'b0, 32'd0, 64'd0));
		plan.push_back(known_row(ACT_NEXT, 64'd0, 32'd0, 32'd0, 3'd4, 1'b0, 32'hFFFF_FFFF,
			64'd0));
		plan.push_back(reg_row(CFG_THRESH, 64'd32768));
		plan.push_back(beat_row(ACT_NEXT, 64'd0, 32'd0, 32'd0));
		// mid-mask seed change keeps the current key
		plan.push_back(reg_row(CFG_SEED, '1));
		plan.push_back(beat_row(ACT_NEXT, 64'd0, 32'd0, 32'd0));
		plan.push_back(known_row(ACT_AUTO, 64'd0, 32'd2, 32'd0, 3'd0, 1'b0, 32'd0, 64'd0));
		plan.push_back(reg_row(CFG_THRESH, 64'd65535));
		plan.push_back(beat_row(ACT_NEXT, 64'd0, 32'd0, 32'd0));

		idle_odds = 2;
		cfg_open = 1'b0;
		foreach (plan[i]) begin
			if (plan[i].is_cfg) begin
				if (!cfg_open)
					settle();
				cfg_open = 1'b1;
				write_reg(plan[i].idx, plan[i].data);
			end else begin
				if (cfg_open)
					cfg_valid <= 1'b0;
				cfg_open = 1'b0;
				offer_beat(plan[i].beat, plan[i].typed, plan[i].want);
			end
		end

		// random traffic, mostly well-formed masks
		random_regs();
		hold_long = 1'b1;
		first = beats_sent;
		while (beats_sent - first < RANDOM_BEATS) begin
			if (beats_sent - first > RANDOM_BEATS - CALM_BEATS)
				calm = 1'b1;
			if (!calm && $urandom_range(0, 11) == 0)
				random_regs();
			else if (!calm && $urandom_range(0, 29) == 0)
				settle();
			b = rand_beat();
			case ($urandom_range(0, 9))
				0: offer_beat(b, 1'b0, '0);
				1: begin
					b.action = ACT_RESERVE;
					case ($urandom_range(0, 3))
						0: b.reserve_count = 32'd0;
						1: b.reserve_count = 32'hFFFF_FFFF;
						2: b.reserve_count = $urandom_range(1, 8);
						default: ;
					endcase
					offer_beat(b, 1'b0, '0);
				end
				default: begin
					len_pick = $urandom_range(0, 9);
					if (len_pick == 0)
						len = 32'd0;
					else if (len_pick == 1)
						len = $urandom;
					else
						len = $urandom_range(1, 48);
					b.mask_length = len;
					if ($urandom_range(0, 1)) begin
						b.action = ACT_AUTO;
					end else begin
						b.action = ACT_EXPLICIT;
						if ($urandom_range(0, 1))
							b.stream_number = $urandom_range(0, 15);
					end
					offer_beat(b, 1'b0, '0);
					if (len > 192)
						groups = $urandom_range(1, 24);
					else
						groups = (len + 3) / 4 + $urandom_range(0, 1);
					// cut some masks short with a new start
					if ($urandom_range(0, 9) == 0)
						groups = $urandom_range(0, groups);
					repeat (groups) begin
						b = rand_beat();
						b.action = ACT_NEXT;
						offer_beat(b, 1'b0, '0);
					end
				end
			endcase
		end

		calm = 1'b1;
		item_valid <= 1'b0;
		while (mask_due.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
